[rtl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, widths and constants for the barometric compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned BscQueueDepth = 4;

  localparam int unsigned RawW  = 24;
  localparam int unsigned CoefW = 16;
  localparam int unsigned TempW = 20;
  localparam int unsigned PresW = 32;

  // internal datapath widths
  localparam int unsigned DtW   = 25;
  localparam int unsigned ProdW = 42;
  localparam int unsigned OffW  = 42;
  localparam int unsigned SensW = 41;
  localparam int unsigned SqW   = 36;
  localparam int unsigned T2W   = 18;
  localparam int unsigned XW    = 44;

  localparam logic signed [TempW-1:0] TempRef = 20'sd2000;
  localparam logic signed [TempW-1:0] TempLow = -20'sd1500;
  localparam logic [CoefW-1:0]        CoefAllOnes = 16'hFFFF;

  typedef struct packed {
    logic [RawW-1:0] pressure_raw;
    logic [RawW-1:0] temperature_raw;
  } bsc_in_t;

  typedef struct packed {
    logic                    result_valid;
    logic signed [TempW-1:0] temperature_centi;
    logic signed [PresW-1:0] pressure_centi;
  } bsc_out_t;

  typedef struct packed {
    logic [CoefW-1:0] coef_sens;
    logic [CoefW-1:0] coef_off;
    logic [CoefW-1:0] coef_tcs;
    logic [CoefW-1:0] coef_tco;
    logic [CoefW-1:0] coef_tref;
    logic [CoefW-1:0] coef_tempsens;
  } bsc_coef_t;

  // classified item between front and back
  typedef struct packed {
    logic            usable;
    logic [RawW-1:0] d1;
    logic [RawW-1:0] d2;
  } bsc_entry_t;

  typedef enum logic [2:0] {
    RegCoefSens,
    RegCoefOff,
    RegCoefTcs,
    RegCoefTco,
    RegCoefTref,
    RegCoefTempsens
  } bsc_reg_e;

  function automatic logic bad_word(input logic [CoefW-1:0] c);
    return (c == '0) || (c == CoefAllOnes);
  endfunction

endpackage

[rtl/bsc_front.sv]
// ----------------------------------------------------------------------------
// bsc_front
// Input stage: takes a raw conversion pair, flags whether it can be used and
// hands it on to the work queue.
// ----------------------------------------------------------------------------
module bsc_front import bsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bsc_coef_t  coef_i,
  input  logic       push_i,
  input  bsc_in_t    item_i,
  output logic       full_o,
  output logic       entry_valid_o,
  output bsc_entry_t entry_o,
  input  logic       entry_ready_i
);

  logic       valid_q, valid_d;
  bsc_entry_t entry_q, entry_d;
  logic       take;

  assign full_o = valid_q && !entry_ready_i;
  assign take   = push_i && !full_o;

  always_comb begin
    entry_d.usable = !bad_word(coef_i.coef_sens) && !bad_word(coef_i.coef_off) &&
                     (item_i.pressure_raw != '0) && (item_i.temperature_raw != '0);
    entry_d.d1     = item_i.pressure_raw;
    entry_d.d2     = item_i.temperature_raw;
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (entry_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= entry_d;
    end
  end

  assign entry_valid_o = valid_q;
  assign entry_o       = entry_q;

endmodule

[rtl/bsc_queue.sv]
// ----------------------------------------------------------------------------
// bsc_queue
// Small first-in first-out buffer of classified items between front and back.
// ----------------------------------------------------------------------------
module bsc_queue import bsc_pkg::*; #(
  parameter int unsigned Depth = BscQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  input  bsc_entry_t wr_data_i,
  output logic       wr_ready_o,
  input  logic       rd_en_i,
  output logic       rd_valid_o,
  output bsc_entry_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsc_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_wr, do_rd;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_en_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/bsc_back.sv]
// ----------------------------------------------------------------------------
// bsc_back
// Compensation pipeline: nine stages from raw pair to temperature and
// pressure, ending in the result register. All stages advance together.
// ----------------------------------------------------------------------------
module bsc_back import bsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bsc_coef_t  coef_i,
  input  logic       src_valid_i,
  input  bsc_entry_t src_data_i,
  output logic       src_pop_o,
  output logic       empty_o,
  output bsc_out_t   result_o,
  input  logic       pop_i
);

  logic adv;
  logic [8:1] v_q;

  // stage 1: dT
  logic                    ok1_q;
  logic [RawW-1:0]         d1_1_q;
  logic signed [DtW-1:0]   dt1_q, dt_d;
  // stage 2: products of dT
  logic                    ok2_q;
  logic [RawW-1:0]         d1_2_q;
  logic signed [ProdW-1:0] pt2_q, po2_q, ps2_q, pt_d, po_d, ps_d;
  logic signed [2*DtW-1:0] dsq_d;
  logic [T2W-1:0]          t2_2_q;
  // stage 3: first-order terms
  logic                    ok3_q;
  logic [RawW-1:0]         d1_3_q;
  logic signed [TempW-1:0] temp3_q, temp3_d;
  logic signed [OffW-1:0]  off3_q, off3_d;
  logic signed [SensW-1:0] sens3_q, sens3_d;
  logic [T2W-1:0]          t2_3_q;
  logic signed [ProdW-1:0] pt_adj, pt_div, ps_sh;
  // stage 4: squares
  logic                    ok4_q, lo4_q, vlo4_q;
  logic [RawW-1:0]         d1_4_q;
  logic signed [TempW-1:0] temp4_q, dta, dtb;
  logic signed [OffW-1:0]  off4_q;
  logic signed [SensW-1:0] sens4_q;
  logic [T2W-1:0]          t2_4_q;
  logic [SqW-1:0]          sqa4_q, sqb4_q;
  logic signed [2*TempW-1:0] sqa_d, sqb_d;
  // stage 5: second-order terms
  logic                    ok5_q;
  logic [RawW-1:0]         d1_5_q;
  logic signed [TempW-1:0] temp5_q;
  logic signed [OffW-1:0]  off5_q;
  logic signed [SensW-1:0] sens5_q;
  logic [T2W-1:0]          t2_5_q, t2_5_d;
  logic [OffW-1:0]         off2_5_q, off2_d, sq61;
  logic [SensW-1:0]        sens2_5_q, sens2_d;
  // stage 6: corrected values
  logic                    ok6_q;
  logic [RawW-1:0]         d1_6_q;
  logic signed [TempW-1:0] temp6_q;
  logic signed [OffW-1:0]  off6_q;
  logic signed [SensW-1:0] sens6_q;
  // stage 7: D1 * SENS partial products
  localparam int unsigned LoW = 20;
  localparam int unsigned HiW = SensW - LoW;
  logic                    ok7_q;
  logic signed [TempW-1:0] temp7_q;
  logic signed [OffW-1:0]  off7_q;
  logic [RawW+LoW-1:0]     mlo7_q, mlo_d;
  logic signed [RawW+HiW:0] mhi7_q, mhi_d;
  // stage 8: pressure before final shift
  localparam int unsigned PW = 66;
  logic                    ok8_q;
  logic signed [TempW-1:0] temp8_q;
  logic signed [XW-1:0]    x8_q, x_d;
  logic signed [PW-1:0]    prod;
  // result register
  logic                    out_v_q;
  bsc_out_t                out_q, out_d;

  assign adv       = !out_v_q || pop_i;
  assign src_pop_o = adv;
  assign empty_o   = !out_v_q;
  assign result_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q     <= {v_q[7:1], src_valid_i};
      out_v_q <= v_q[8];
    end
  end

  // stage 1
  assign dt_d = $signed({1'b0, src_data_i.d2}) - $signed({1'b0, coef_i.coef_tref, 8'd0});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok1_q  <= src_data_i.usable;
      d1_1_q <= src_data_i.d1;
      dt1_q  <= dt_d;
    end
  end

  // stage 2
  always_comb begin
    pt_d  = dt1_q * $signed({1'b0, coef_i.coef_tempsens});
    po_d  = dt1_q * $signed({1'b0, coef_i.coef_tco});
    ps_d  = dt1_q * $signed({1'b0, coef_i.coef_tcs});
    dsq_d = dt1_q * dt1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok2_q  <= ok1_q;
      d1_2_q <= d1_1_q;
      pt2_q  <= pt_d;
      po2_q  <= po_d;
      ps2_q  <= ps_d;
      t2_2_q <= dsq_d[T2W+30:31];
    end
  end

  // stage 3: division by 2^23 truncates toward zero, the other shifts floor
  always_comb begin
    pt_adj  = pt2_q + $signed({19'd0, {23{pt2_q[ProdW-1]}}});
    pt_div  = pt_adj >>> 23;
    temp3_d = TempRef + $signed(pt_div[TempW-1:0]);
    off3_d  = $signed({9'd0, coef_i.coef_off, 17'd0}) + (po2_q >>> 6);
    ps_sh   = ps2_q >>> 7;
    sens3_d = $signed({9'd0, coef_i.coef_sens, 16'd0}) + $signed(ps_sh[SensW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok3_q   <= ok2_q;
      d1_3_q  <= d1_2_q;
      temp3_q <= temp3_d;
      off3_q  <= off3_d;
      sens3_q <= sens3_d;
      t2_3_q  <= t2_2_q;
    end
  end

  // stage 4
  always_comb begin
    dta   = temp3_q - TempRef;
    dtb   = temp3_q - TempLow;
    sqa_d = dta * dta;
    sqb_d = dtb * dtb;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok4_q   <= ok3_q;
      d1_4_q  <= d1_3_q;
      temp4_q <= temp3_q;
      off4_q  <= off3_q;
      sens4_q <= sens3_q;
      t2_4_q  <= t2_3_q;
      sqa4_q  <= sqa_d[SqW-1:0];
      sqb4_q  <= sqb_d[SqW-1:0];
      lo4_q   <= (temp3_q < TempRef);
      vlo4_q  <= (temp3_q < TempLow);
    end
  end

  // stage 5: second-order terms, zero above 20.00 C
  always_comb begin
    sq61    = OffW'(sqa4_q) * OffW'(61);
    off2_d  = '0;
    sens2_d = '0;
    t2_5_d  = '0;
    if (lo4_q) begin
      t2_5_d  = t2_4_q;
      off2_d  = sq61 >> 4;
      sens2_d = SensW'({sqa4_q, 1'b0});
      if (vlo4_q) begin
        off2_d  = off2_d + OffW'(sqb4_q) * OffW'(15);
        sens2_d = sens2_d + SensW'({sqb4_q, 3'b0});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok5_q     <= ok4_q;
      d1_5_q    <= d1_4_q;
      temp5_q   <= temp4_q;
      off5_q    <= off4_q;
      sens5_q   <= sens4_q;
      t2_5_q    <= t2_5_d;
      off2_5_q  <= off2_d;
      sens2_5_q <= sens2_d;
    end
  end

  // stage 6
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok6_q   <= ok5_q;
      d1_6_q  <= d1_5_q;
      temp6_q <= temp5_q - $signed({2'b0, t2_5_q});
      off6_q  <= off5_q - $signed(off2_5_q);
      sens6_q <= sens5_q - $signed(sens2_5_q);
    end
  end

  // stage 7: sens split in an unsigned low half and a signed high half
  always_comb begin
    mlo_d = (RawW+LoW)'(d1_6_q) * (RawW+LoW)'(sens6_q[LoW-1:0]);
    mhi_d = $signed({1'b0, d1_6_q}) * $signed(sens6_q[SensW-1:LoW]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok7_q   <= ok6_q;
      temp7_q <= temp6_q;
      off7_q  <= off6_q;
      mlo7_q  <= mlo_d;
      mhi7_q  <= mhi_d;
    end
  end

  // stage 8
  always_comb begin
    prod = ($signed({{(PW-RawW-HiW-1){mhi7_q[RawW+HiW]}}, mhi7_q}) <<< LoW) +
           $signed({{(PW-RawW-LoW){1'b0}}, mlo7_q});
    x_d  = $signed(prod[XW+20:21]) - $signed({{(XW-OffW){off7_q[OffW-1]}}, off7_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok8_q   <= ok7_q;
      temp8_q <= temp7_q;
      x8_q    <= x_d;
    end
  end

  // result register; |x| stays below 2^42, so P never reaches the 32-bit clamp
  always_comb begin
    out_d.result_valid      = ok8_q;
    out_d.temperature_centi = '0;
    out_d.pressure_centi    = '0;
    if (ok8_q) begin
      out_d.temperature_centi = temp8_q;
      out_d.pressure_centi    = $signed({{(PresW-XW+15){x8_q[XW-1]}}, x8_q[XW-1:15]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

endmodule

[rtl/baro_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order temperature and pressure compensation of raw barometer
// conversions, with six calibration words on an APB-style port.
// ----------------------------------------------------------------------------
// throughput: one pair per cycle while full is low; the nine-stage pipeline
//   holds while a finished result waits and the four-entry queue keeps
//   taking pushes until it fills
// reset: clears all valid bits, queue pointers and the calibration words
//   (all zero, so results read invalid until C1 and C2 are written)
module baro_sensor_compensation import bsc_pkg::*; #(
  parameter int unsigned QueueDepth = BscQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  bsc_in_t     item_i,
  output logic        empty,
  input  logic        pop,
  output bsc_out_t    result_o
);

  bsc_coef_t  coef_q, coef_d;
  bsc_reg_e   reg_idx;
  logic       wr_en;
  logic       fe_valid, fe_ready, bk_valid, bk_pop;
  bsc_entry_t fe_entry, bk_entry;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = bsc_reg_e'(paddr[4:2]);

  always_comb begin
    coef_d = coef_q;
    if (wr_en) begin
      case (reg_idx)
        RegCoefSens:     coef_d.coef_sens     = pwdata[CoefW-1:0];
        RegCoefOff:      coef_d.coef_off      = pwdata[CoefW-1:0];
        RegCoefTcs:      coef_d.coef_tcs      = pwdata[CoefW-1:0];
        RegCoefTco:      coef_d.coef_tco      = pwdata[CoefW-1:0];
        RegCoefTref:     coef_d.coef_tref     = pwdata[CoefW-1:0];
        RegCoefTempsens: coef_d.coef_tempsens = pwdata[CoefW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCoefSens:     prdata = {16'd0, coef_q.coef_sens};
      RegCoefOff:      prdata = {16'd0, coef_q.coef_off};
      RegCoefTcs:      prdata = {16'd0, coef_q.coef_tcs};
      RegCoefTco:      prdata = {16'd0, coef_q.coef_tco};
      RegCoefTref:     prdata = {16'd0, coef_q.coef_tref};
      RegCoefTempsens: prdata = {16'd0, coef_q.coef_tempsens};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  bsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coef_i        (coef_q),
    .push_i        (push),
    .item_i        (item_i),
    .full_o        (full),
    .entry_valid_o (fe_valid),
    .entry_o       (fe_entry),
    .entry_ready_i (fe_ready)
  );

  bsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_data_i  (fe_entry),
    .wr_ready_o (fe_ready),
    .rd_en_i    (bk_pop),
    .rd_valid_o (bk_valid),
    .rd_data_o  (bk_entry)
  );

  bsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .src_valid_i (bk_valid),
    .src_data_i  (bk_entry),
    .src_pop_o   (bk_pop),
    .empty_o     (empty),
    .result_o    (result_o),
    .pop_i       (pop)
  );

endmodule

[tb/sv/bsc_checker.sv]
// ----------------------------------------------------------------------------
// bsc_checker
// Watches the calibration port and both queue channels of the barometric
// compensation block. It keeps its own copy of the calibration words and
// computes each expected result at the push beat. Each pop beat is compared
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module bsc_checker import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        push_i,
  input  logic        full_i,
  input  bsc_in_t     item_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  bsc_out_t    result_i,
  output int          outstanding_o = 0,
  output int          mismatches_o = 0
);

  localparam longint PresMax = 64'sd2147483647;
  localparam longint PresMin = -64'sd2147483648;

  bsc_coef_t calib = '0;
  bsc_out_t  compensated_q[$];
  int        fail_count = 0;

  // second-order compensation, all in 64-bit signed arithmetic
  function automatic bsc_out_t compensate(input bsc_coef_t cf, input bsc_in_t pair);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, off2, sens2, sq, sq_low, p;
    bsc_out_t r;
    r = '0;
    if (cf.coef_sens == '0 || cf.coef_sens == '1 || cf.coef_off == '0 ||
        cf.coef_off == '1 || pair.pressure_raw == '0 || pair.temperature_raw == '0) begin
      return r;
    end
    d1 = longint'({40'd0, pair.pressure_raw});
    d2 = longint'({40'd0, pair.temperature_raw});
    c1 = longint'({48'd0, cf.coef_sens});
    c2 = longint'({48'd0, cf.coef_off});
    c3 = longint'({48'd0, cf.coef_tcs});
    c4 = longint'({48'd0, cf.coef_tco});
    c5 = longint'({48'd0, cf.coef_tref});
    c6 = longint'({48'd0, cf.coef_tempsens});

    dt   = d2 - c5 * 256;
    // signed division truncates toward zero, the shifts round toward minus infinity
    temp = 2000 + (dt * c6) / 8388608;
    off  = c2 * 131072 + ((c4 * dt) >>> 6);
    sens = c1 * 65536 + ((c3 * dt) >>> 7);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (temp < 2000) begin
      sq    = (temp - 2000) * (temp - 2000);
      t2    = (dt * dt) >>> 31;
      off2  = (61 * sq) >>> 4;
      sens2 = 2 * sq;
      if (temp < -1500) begin
        sq_low = (temp + 1500) * (temp + 1500);
        off2  += 15 * sq_low;
        sens2 += 8 * sq_low;
      end
    end
    temp -= t2;
    off  -= off2;
    sens -= sens2;

    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p > PresMax) p = PresMax;
    if (p < PresMin) p = PresMin;

    r.result_valid      = 1'b1;
    r.temperature_centi = temp[TempW-1:0];
    r.pressure_centi    = p[PresW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    bsc_out_t want;
    if (!rst_ni) begin
      calib = '0;
      compensated_q.delete();
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          RegCoefSens:     calib.coef_sens     = pwdata_i[CoefW-1:0];
          RegCoefOff:      calib.coef_off      = pwdata_i[CoefW-1:0];
          RegCoefTcs:      calib.coef_tcs      = pwdata_i[CoefW-1:0];
          RegCoefTco:      calib.coef_tco      = pwdata_i[CoefW-1:0];
          RegCoefTref:     calib.coef_tref     = pwdata_i[CoefW-1:0];
          RegCoefTempsens: calib.coef_tempsens = pwdata_i[CoefW-1:0];
          default: ;
        endcase
      end

      if (pop_i && !empty_i) begin
        if (compensated_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result beat: valid %0b temp %0d pres %0d",
                     result_i.result_valid, result_i.temperature_centi,
                     result_i.pressure_centi);
          end
        end else begin
          want = compensated_q.pop_front();
          if (result_i.result_valid !== want.result_valid ||
              result_i.temperature_centi !== want.temperature_centi ||
              result_i.pressure_centi !== want.pressure_centi) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: expected valid %0b temp %0d pres %0d, got valid %0b temp %0d pres %0d",
                       want.result_valid, want.temperature_centi, want.pressure_centi,
                       result_i.result_valid, result_i.temperature_centi,
                       result_i.pressure_centi);
            end
          end
        end
      end

      if (push_i && !full_i) begin
        compensated_q.push_back(compensate(calib, item_i));
      end

      outstanding_o <= compensated_q.size();
    end
    mismatches_o <= fail_count;
  end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the barometric compensation block. A directed part covers
// the calibration extremes, invalid calibration words, zero raw values and
// both second-order temperature bands. Random phases with new calibration
// follow. Push and pop gaps and a long pop hold-off are included. The
// checker beside the block supplies the mismatch count for the verdict.
// ----------------------------------------------------------------------------
module testbench import bsc_pkg::*;;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandPhases  = 8;
  localparam int unsigned PhaseItems  = 240;
  localparam int unsigned DrainCycles = 24;

  // addresses past the last calibration word, writes there are dropped
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  bsc_in_t     item = '0;
  logic        empty;
  logic        pop = 1'b0;
  bsc_out_t    result;

  int          outstanding;
  int          mismatches;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;

  baro_sensor_compensation i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .full     (full),
    .item_i   (item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result)
  );

  bsc_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .push_i        (push),
    .full_i        (full),
    .item_i        (item),
    .empty_i       (empty),
    .pop_i         (pop),
    .result_i      (result),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // result side: random gaps, or a long hold-off counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= no_gaps || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_coefs(input bsc_coef_t cf);
    apb_write(RegCoefSens, cf.coef_sens);
    apb_write(RegCoefOff, cf.coef_off);
    apb_write(RegCoefTcs, cf.coef_tcs);
    apb_write(RegCoefTco, cf.coef_tco);
    apb_write(RegCoefTref, cf.coef_tref);
    apb_write(RegCoefTempsens, cf.coef_tempsens);
  endtask

  task automatic send_raw(input logic [23:0] d1, input logic [23:0] d2);
    while (!no_gaps && $urandom_range(0, 99) < 7) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{pressure_raw: d1, temperature_raw: d2};
    do @(posedge clk); while (full);
  endtask

  // stop pushing and wait for every outstanding result beat
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coef(input bit calib_word);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (calib_word && sel < 3) return 16'h0000;
    if (calib_word && sel < 6) return 16'hFFFF;
    if (!calib_word && sel < 8) return 16'h0000;
    if (!calib_word && sel < 16) return 16'hFFFF;
    if (sel < 22) return 16'hFFFE;
    if (sel < 28) return 16'h0001;
    return 16'($urandom);
  endfunction

  // often temperatures near the reference point so that all bands are hit
  function automatic bsc_in_t rand_pair(input logic [15:0] tref);
    int unsigned sel;
    int          span;
    int          t;
    bsc_in_t     p;
    sel = $urandom_range(0, 99);
    p.pressure_raw    = 24'($urandom);
    p.temperature_raw = 24'($urandom);
    if (sel < 45) begin
      span = 1 << (4 * $urandom_range(2, 5) + 3);
      t = int'({8'd0, tref, 8'd0});
      t = t + int'($urandom_range(0, 2 * span)) - span;
      if (t < 1) t = 1;
      if (t > 16777215) t = 16777215;
      p.temperature_raw = t[23:0];
    end else if (sel < 60) begin
      if ($urandom_range(0, 1)) p.pressure_raw = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd1;
      if ($urandom_range(0, 1)) p.temperature_raw = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd1;
    end else if (sel < 68) begin
      case ($urandom_range(0, 2))
        0:       p.pressure_raw = '0;
        1:       p.temperature_raw = '0;
        default: p = '0;
      endcase
    end
    return p;
  endfunction

  initial begin : stimulus
    bsc_coef_t cfg;
    bsc_in_t   pair;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // calibration still at reset, every result reads invalid
    send_raw(24'd6465444, 24'd8077636);
    drain_results();

    // datasheet calibration
    cfg = '{coef_sens: 16'd46372, coef_off: 16'd43981, coef_tcs: 16'd29059,
            coef_tco: 16'd27842, coef_tref: 16'd31553, coef_tempsens: 16'd28165};
    load_coefs(cfg);
    send_raw(24'd6465444, 24'd8077636);
    send_raw(24'd0, 24'd8077636);
    send_raw(24'd6465444, 24'd0);
    send_raw(24'd0, 24'd0);
    send_raw(24'hFFFFFF, 24'hFFFFFF);
    send_raw(24'd1, 24'd1);
    send_raw(24'd6465444, 24'd8077568);   // dt zero, exactly 20.00 C
    send_raw(24'd6465444, 24'd8077268);   // just below 20.00 C
    send_raw(24'd6465444, 24'd7035168);   // near -15.00 C
    send_raw(24'd6465444, 24'd6900000);   // below -15.00 C
    drain_results();

    // writes past the last word must leave the calibration alone
    apb_write(RegSpareLo, 16'h0000);
    apb_write(RegSpareHi, 16'hFFFF);
    send_raw(24'd6465444, 24'd8077636);
    drain_results();

    // each invalid calibration word
    apb_write(RegCoefSens, 16'hFFFF);
    send_raw(24'd6465444, 24'd8077636);
    drain_results();
    apb_write(RegCoefSens, 16'd46372);
    apb_write(RegCoefOff, 16'h0000);
    send_raw(24'd6465444, 24'd8077636);
    drain_results();
    apb_write(RegCoefOff, 16'hFFFF);
    send_raw(24'd6465444, 24'd8077636);
    drain_results();

    // largest usable words with the reference temperature at both ends
    cfg = '{coef_sens: 16'hFFFE, coef_off: 16'hFFFE, coef_tcs: 16'hFFFF,
            coef_tco: 16'hFFFF, coef_tref: 16'h0000, coef_tempsens: 16'hFFFF};
    load_coefs(cfg);
    send_raw(24'hFFFFFF, 24'hFFFFFF);
    send_raw(24'd1, 24'd1);
    send_raw(24'hFFFFFF, 24'd1);
    drain_results();
    apb_write(RegCoefTref, 16'hFFFF);
    send_raw(24'd1, 24'd1);
    send_raw(24'hFFFFFF, 24'd1);
    send_raw(24'hFFFFFF, 24'hFFFFFF);
    drain_results();

    for (int phase = 0; phase < RandPhases; phase++) begin
      if (phase == 0) begin
        cfg = '{coef_sens: 16'hFFFE, coef_off: 16'hFFFE, coef_tcs: 16'hFFFF,
                coef_tco: 16'hFFFF, coef_tref: 16'hFFFF, coef_tempsens: 16'hFFFF};
      end else if (phase == 1) begin
        cfg = '{coef_sens: 16'h0001, coef_off: 16'h0001, coef_tcs: 16'h0000,
                coef_tco: 16'h0000, coef_tref: 16'h0000, coef_tempsens: 16'h0000};
      end else begin
        cfg.coef_sens     = rand_coef(1'b1);
        cfg.coef_off      = rand_coef(1'b1);
        cfg.coef_tcs      = rand_coef(1'b0);
        cfg.coef_tco      = rand_coef(1'b0);
        cfg.coef_tref     = rand_coef(1'b0);
        cfg.coef_tempsens = rand_coef(1'b0);
      end
      load_coefs(cfg);
      no_gaps = (phase == 5);
      for (int n = 0; n < PhaseItems; n++) begin
        // hold off the result side while pushes keep coming, to fill the block
        if (phase == 3 && n == 40) hold_req = 1'b1;
        pair = rand_pair(cfg.coef_tref);
        send_raw(pair.pressure_raw, pair.temperature_raw);
      end
      drain_results();
    end
    no_gaps = 1'b0;

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
